### hw/rtl/pgpa_pkg.sv
// pgpa_pkg: shared types, constants and helper functions for the glyph pixel block
package pgpa_pkg;

  // byte store size, power of two
  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
  localparam int unsigned HEADER_BYTES = 5;
  // sum of header base, row offset and column byte before wrapping
  localparam int unsigned SUM_W = (STORE_AW > 17) ? STORE_AW : 17;

  typedef logic [STORE_AW-1:0] store_addr_t;

  typedef enum logic [1:0] {
    MODE_PIX_RD = 2'd0,
    MODE_PIX_WR = 2'd1,
    MODE_RAW_WR = 2'd2,
    MODE_RAW_RD = 2'd3
  } pgpa_mode_e;

  typedef enum logic [1:0] {
    DEPTH_1B = 2'd0,
    DEPTH_2B = 2'd1,
    DEPTH_4B = 2'd2
  } pgpa_depth_e;

  localparam logic [1:0] DEPTH_RESET = DEPTH_4B;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } pgpa_state_e;

  // decoded request handed from the address decoder to the control
  typedef struct packed {
    store_addr_t addr;
    logic [2:0]  shift;
    logic        on_glyph;
    logic        black;
    logic [7:0]  avg;
  } pgpa_dec_t;

  function automatic logic [7:0] field_mask(input logic [1:0] depth);
    logic [7:0] m;
    case (depth)
      DEPTH_1B: m = 8'h01;
      DEPTH_2B: m = 8'h03;
      DEPTH_4B: m = 8'h0F;
      default:  m = 8'h00;
    endcase
    return m;
  endfunction

  // inverted gray for a packed pixel value
  function automatic logic [7:0] gray_of(input logic [1:0] depth, input logic [3:0] d);
    logic [7:0] g;
    case (depth)
      DEPTH_1B: g = d[0] ? 8'd0 : 8'd255;
      DEPTH_2B: g = 8'({6'd0, ~d[1:0]} * 8'd85);
      DEPTH_4B: g = 8'({4'd0, ~d} * 8'd17);
      default:  g = 8'd0;
    endcase
    return g;
  endfunction

  // floor(v * 3 / 255)
  function automatic logic [1:0] quant2(input logic [7:0] v);
    logic [1:0] q;
    if (v == 8'd255) begin
      q = 2'd3;
    end else if (v >= 8'd170) begin
      q = 2'd2;
    end else if (v >= 8'd85) begin
      q = 2'd1;
    end else begin
      q = 2'd0;
    end
    return q;
  endfunction

endpackage

### hw/rtl/pgpa_in_if.sv
// pgpa_in_if: request channel carrying one access word
interface pgpa_in_if
  import pgpa_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] glyph_offset;
  logic [7:0]  glyph_width;
  logic [7:0]  glyph_height;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  raw_byte;

  modport source (
    output valid, mode, glyph_offset, glyph_width, glyph_height,
           pixel_x, pixel_y, red, green, blue, raw_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, glyph_offset, glyph_width, glyph_height,
           pixel_x, pixel_y, red, green, blue, raw_byte,
    output ready
  );
endinterface

### hw/rtl/pgpa_out_if.sv
// pgpa_out_if: result channel carrying one response word
interface pgpa_out_if
  import pgpa_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic       accepted;
  logic [7:0] read_byte;

  modport source (output valid, gray, accepted, read_byte, input ready);
  modport sink   (input valid, gray, accepted, read_byte, output ready);
endinterface

### hw/rtl/pgpa_decode.sv
// pgpa_decode: byte address, bit position, bounds check and colour average
module pgpa_decode
  import pgpa_pkg::*;
(
  input  logic [1:0]  mode_i,
  input  logic [1:0]  depth_i,
  input  logic [15:0] glyph_offset_i,
  input  logic [7:0]  glyph_width_i,
  input  logic [7:0]  glyph_height_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output pgpa_dec_t   dec_o
);

  logic [7:0]       row_bytes;
  logic [15:0]      row_off;
  logic [7:0]       col_byte;
  logic [2:0]       bit_shift;
  store_addr_t      byte_addr;
  logic [SUM_W-1:0] pix_sum;
  logic [SUM_W-1:0] raw_sum;
  logic [9:0]       rgb_sum;
  logic [19:0]      avg_prod;
  logic             depth_ok;

  assign row_bytes = 8'(({1'b0, glyph_width_i} + 9'd1) >> 1);
  assign row_off   = pixel_y_i * row_bytes;

  always_comb begin
    case (depth_i)
      DEPTH_1B: begin
        col_byte  = pixel_x_i >> 3;
        bit_shift = 3'd7 - pixel_x_i[2:0];
        depth_ok  = 1'b1;
      end
      DEPTH_2B: begin
        col_byte  = pixel_x_i >> 2;
        bit_shift = {~pixel_x_i[1:0], 1'b0};
        depth_ok  = 1'b1;
      end
      DEPTH_4B: begin
        col_byte  = pixel_x_i >> 1;
        bit_shift = {~pixel_x_i[0], 2'b00};
        depth_ok  = 1'b1;
      end
      default: begin
        col_byte  = 8'd0;
        bit_shift = 3'd0;
        depth_ok  = 1'b0;
      end
    endcase
  end

  assign pix_sum = SUM_W'(glyph_offset_i) + SUM_W'(HEADER_BYTES) + SUM_W'(row_off)
                 + SUM_W'(col_byte);
  assign raw_sum = SUM_W'(glyph_offset_i);

  // raw modes address the byte directly, pixel modes go past the header
  always_comb begin
    if (mode_i == MODE_RAW_WR || mode_i == MODE_RAW_RD) begin
      byte_addr = raw_sum[STORE_AW-1:0];
    end else begin
      byte_addr = pix_sum[STORE_AW-1:0];
    end
  end

  // divide by three as multiply by 683/2048, exact for sums up to 765
  assign rgb_sum  = 10'(red_i) + 10'(green_i) + 10'(blue_i);
  assign avg_prod = rgb_sum * 10'd683;

  assign dec_o = '{
    addr:     byte_addr,
    shift:    bit_shift,
    on_glyph: depth_ok && (pixel_x_i < glyph_width_i) && (pixel_y_i < glyph_height_i),
    black:    ~|{red_i, green_i, blue_i},
    avg:      avg_prod[18:11]
  };

endmodule

### hw/rtl/pgpa_store.sv
// pgpa_store: glyph byte store, one write and one registered read port
module pgpa_store
  import pgpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        re_i,
  input  store_addr_t raddr_i,
  input  logic        we_i,
  input  store_addr_t waddr_i,
  input  logic [7:0]  wdata_i,
  output logic [7:0]  rdata_o
);

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/packed_glyph_pixel_access.sv
// packed_glyph_pixel_access: top level, access sequencer and result register
//
//   channel   | direction | handshake            | carries
//   in_i      | in        | valid/ready          | mode, glyph geometry, pixel, colour, raw byte
//   out_o     | out       | valid/ready          | gray, accepted, read_byte
//   depth_*   | in        | depth_we_i only      | pixel depth register
//
// an access is accepted in ST_IDLE, where the accept issues the store read; ST_EXEC then
// merges or unpacks the byte, writes it back and loads the result register.
// a full result register holds ST_EXEC until out_o is taken, and a new word is accepted
// only back in ST_IDLE, so an item is not taken before the last one is through.
// reset clears the control and sets the depth register to 4-bit depth; the store is not cleared.
module packed_glyph_pixel_access
  import pgpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        depth_we_i,
  input  logic [1:0]  depth_wdata_i,
  pgpa_in_if.sink     in_i,
  pgpa_out_if.source  out_o
);

  pgpa_state_e state_q, state_d;
  logic [1:0]  depth_q;

  pgpa_dec_t   dec;
  pgpa_dec_t   dec_q;
  pgpa_mode_e  mode_q;
  logic [7:0]  raw_q;

  logic        in_accept;
  logic        out_free;
  logic        exec_done;
  logic        store_we;
  logic [7:0]  store_wdata;
  logic [7:0]  rdata;

  logic [7:0]  fmask;
  logic [7:0]  fld_mask;
  logic [7:0]  pix_val;
  logic [7:0]  inv_avg;
  logic [15:0] q15_prod;
  logic [3:0]  wr_d;
  logic [7:0]  merged;

  logic        out_valid_q;
  logic [7:0]  gray_q, gray_d;
  logic        acc_q, acc_d;
  logic [7:0]  rbyte_q, rbyte_d;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (depth_we_i) begin
      depth_q <= depth_wdata_i;
    end
  end

  pgpa_decode u_decode (
    .mode_i         (in_i.mode),
    .depth_i        (depth_q),
    .glyph_offset_i (in_i.glyph_offset),
    .glyph_width_i  (in_i.glyph_width),
    .glyph_height_i (in_i.glyph_height),
    .pixel_x_i      (in_i.pixel_x),
    .pixel_y_i      (in_i.pixel_y),
    .red_i          (in_i.red),
    .green_i        (in_i.green),
    .blue_i         (in_i.blue),
    .dec_o          (dec)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    exec_done  = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_EXEC: exec_done  = out_free;
      default: in_i.ready = 1'b0;
    endcase
  end

  assign in_accept = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dec_q  <= dec;
      mode_q <= pgpa_mode_e'(in_i.mode);
      raw_q  <= in_i.raw_byte;
    end
  end

  pgpa_store u_store (
    .clk_i   (clk_i),
    .re_i    (in_accept),
    .raddr_i (dec.addr),
    .we_i    (store_we),
    .waddr_i (dec_q.addr),
    .wdata_i (store_wdata),
    .rdata_o (rdata)
  );

  // unpack and merge
  assign fmask    = field_mask(depth_q);
  assign fld_mask = 8'(fmask << dec_q.shift);
  assign pix_val  = (rdata >> dec_q.shift) & fmask;
  assign inv_avg  = 8'd255 - dec_q.avg;
  // divide by seventeen as multiply by 241/4096, exact below 256
  assign q15_prod = inv_avg * 8'd241;

  always_comb begin
    case (depth_q)
      DEPTH_1B: wr_d = {3'd0, dec_q.black};
      DEPTH_2B: wr_d = {2'd0, quant2(inv_avg)};
      DEPTH_4B: wr_d = q15_prod[15:12];
      default:  wr_d = 4'd0;
    endcase
  end

  assign merged = (rdata & ~fld_mask) | 8'((8'(wr_d) & fmask) << dec_q.shift);

  always_comb begin
    store_we    = 1'b0;
    store_wdata = merged;
    gray_d      = 8'd0;
    acc_d       = 1'b0;
    rbyte_d     = 8'd0;
    case (mode_q)
      MODE_PIX_RD: begin
        acc_d  = dec_q.on_glyph;
        gray_d = dec_q.on_glyph ? gray_of(depth_q, pix_val[3:0]) : 8'd0;
      end
      MODE_PIX_WR: begin
        acc_d    = dec_q.on_glyph;
        store_we = exec_done && dec_q.on_glyph;
      end
      MODE_RAW_WR: begin
        acc_d       = 1'b1;
        store_we    = exec_done;
        store_wdata = raw_q;
      end
      MODE_RAW_RD: begin
        acc_d   = 1'b1;
        rbyte_d = rdata;
      end
      default: acc_d = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      gray_q  <= gray_d;
      acc_q   <= acc_d;
      rbyte_q <= rbyte_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.gray      = gray_q;
  assign out_o.accepted  = acc_q;
  assign out_o.read_byte = rbyte_q;

  // checks
  a_we_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == ST_EXEC))
    else $error("store written outside the execute cycle");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_EXEC))
    else $error("accepted word did not enter execute");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without an execute cycle");

  a_gray_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !acc_q) |-> (gray_q == 8'd0 && rbyte_q == 8'd0))
    else $error("nonzero result data on a refused access");

  a_one_data_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (gray_q == 8'd0 || rbyte_q == 8'd0))
    else $error("gray and read byte both set");

endmodule
